// ===== hw/rtl/tegrid_pkg.sv =====
package tegrid_pkg;

   localparam int DEF_GRID_ROWS    = 64;
   localparam int DEF_GRID_COLUMNS = 64;

   localparam int HW = 16;

   localparam logic [7:0]  RST_PASS_COUNT  = 8'd1;
   localparam logic [15:0] RST_TALUS       = 16'd655;
   localparam logic [15:0] RST_MAX_HEIGHT  = 16'd65535;
   localparam logic [5:0]  RST_LAST_ROW    = 6'd63;
   localparam logic [5:0]  RST_LAST_COLUMN = 6'd63;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_PASS_COUNT  = 3'd0,
      CSR_TALUS       = 3'd1,
      CSR_MAX_HEIGHT  = 3'd2,
      CSR_LAST_ROW    = 3'd3,
      CSR_LAST_COLUMN = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic run_init;
      logic ld_issue;
      logic ld_capture;
      logic idx_clr;
      logic idx_inc;
      logic mv_sq;
      logic mv_cube;
      logic mv_scale;
      logic div_start;
      logic mv_apply;
      logic wr_self;
   } ctl_cmd_type;

   typedef struct packed {
      logic pass_zero;
      logic last_slot;
      logic recv_cur;
      logic last_k;
      logic div_done;
      logic at_end;
   } dp_stat_type;

endpackage

// ===== hw/rtl/thermal_erosion_grid.sv =====
// Height grid with a talus-slide erosion engine.
// Requests: start with req_cmd, req_row, req_column, req_height_in; a request
// is taken at a clock edge where start is high and busy is low.
// Commands: write one height, read one height, or run pass_count erosion
// passes in place over rows 0..last_row and columns 0..last_column.
// Every request gives exactly one response: rsp_strobe is high for one cycle
// with rsp_height_out (read data, else zero) and rsp_run_done (run only).
// Write and read: response in the cycle after the request; busy stays low, so a
// new request can be taken every cycle.
// Run: busy is high for the whole run. Each vertex reads itself and its four
// diagonal neighbors and then writes itself back; each neighbor that takes
// material also passes a squaring, cubing and scaling multiplier chain and a
// shift-subtract divider. The single port grid memory sets the load cost.
// The response comes the cycle after the last write-back.
// Configuration through csr_write_enable/csr_index/csr_write_data: the user
// must write only while no request is in progress; the block does not check.
// Reset restores register defaults and idles the engine; grid contents are
// undefined until written. The receiver cannot stall responses.
module thermal_erosion_grid #(
   parameter int GRID_ROWS    = tegrid_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLUMNS = tegrid_pkg::DEF_GRID_COLUMNS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_row,
   input  logic [5:0]  req_column,
   input  logic [15:0] req_height_in,
   output logic        rsp_strobe,
   output logic [15:0] rsp_height_out,
   output logic        rsp_run_done,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   tegrid_pkg::ctl_cmd_type cmd;
   tegrid_pkg::dp_stat_type stat;

   tegrid_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_cmd      (req_cmd),
      .stat         (stat),
      .cmd          (cmd),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_run_done (rsp_run_done)
   );

   tegrid_dp #(
      .GRID_ROWS    (GRID_ROWS),
      .GRID_COLUMNS (GRID_COLUMNS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_row          (req_row),
      .req_column       (req_column),
      .req_height_in    (req_height_in),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_height_out   (rsp_height_out)
   );

`ifndef NO_ASSERTIONS
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("response while busy");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_run_done |-> rsp_strobe) else $error("run_done without strobe");

   a_height_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_height_out != 16'd0) |-> (rsp_strobe && !rsp_run_done))
      else $error("height outside read response");

   a_short_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd != tegrid_pkg::CMD_RUN) |=> rsp_strobe)
      else $error("missing response to write or read");
`endif

endmodule

// ===== hw/rtl/tegrid_div.sv =====
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in 16 bits, so the upper dividend half starts below the divisor.
module tegrid_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [17:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);

   logic        running_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [17:0] rem_ff;
   logic [15:0] low_ff;
   logic [15:0] q_ff;
   logic [18:0] trial;
   logic        fits;

   assign trial = {rem_ff, low_ff[15]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            running_ff <= 1'b1;
            cnt_ff     <= 5'd0;
            rem_ff     <= {2'b00, dividend[31:16]};
            low_ff     <= dividend[15:0];
            q_ff       <= 16'd0;
         end else if (running_ff) begin
            rem_ff <= fits ? 18'(trial - {1'b0, divisor}) : trial[17:0];
            q_ff   <= {q_ff[14:0], fits};
            low_ff <= {low_ff[14:0], 1'b0};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== hw/rtl/tegrid_dp.sv =====
module tegrid_dp #(
   parameter int GRID_ROWS    = tegrid_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLUMNS = tegrid_pkg::DEF_GRID_COLUMNS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tegrid_pkg::ctl_cmd_type cmd,
   output tegrid_pkg::dp_stat_type stat,
   input  logic [1:0]              req_cmd,
   input  logic [5:0]              req_row,
   input  logic [5:0]              req_column,
   input  logic [15:0]             req_height_in,
   input  logic                    csr_write_enable,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_write_data,
   output logic [15:0]             rsp_height_out
);

   localparam int DEPTH = GRID_ROWS * GRID_COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   function automatic logic [AW-1:0] addr_of(input logic [5:0] r, input logic [5:0] c);
      addr_of = AW'(32'(r) * GRID_COLUMNS + 32'(c));
   endfunction

   // configuration
   logic [7:0]  pass_count_ff;
   logic [15:0] talus_ff;
   logic [15:0] max_height_ff;
   logic [5:0]  last_row_ff;
   logic [5:0]  last_column_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_count_ff  <= tegrid_pkg::RST_PASS_COUNT;
         talus_ff       <= tegrid_pkg::RST_TALUS;
         max_height_ff  <= tegrid_pkg::RST_MAX_HEIGHT;
         last_row_ff    <= tegrid_pkg::RST_LAST_ROW;
         last_column_ff <= tegrid_pkg::RST_LAST_COLUMN;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tegrid_pkg::CSR_PASS_COUNT:  pass_count_ff  <= csr_write_data[7:0];
            tegrid_pkg::CSR_TALUS:       talus_ff       <= csr_write_data;
            tegrid_pkg::CSR_MAX_HEIGHT:  max_height_ff  <= csr_write_data;
            tegrid_pkg::CSR_LAST_ROW:    last_row_ff    <= csr_write_data[5:0];
            tegrid_pkg::CSR_LAST_COLUMN: last_column_ff <= csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   // walk state
   logic [5:0]  r_ff, c_ff, lr_ff, lc_ff;
   logic [7:0]  pass_ff;
   logic [2:0]  idx_ff;
   logic [15:0] h_ff;
   logic [17:0] dsum_ff;
   logic [15:0] dtop_ff;
   logic        recv_ff [4];
   logic [15:0] drop_ff [4];
   logic [15:0] nval_ff [4];
   logic [AW-1:0] naddr_ff [4];
   logic        neg_ff;
   logic [31:0] sq_ff;
   logic [15:0] cube_ff;
   logic [15:0] scaled_ff;
   logic        rd_ok_ff;
   logic [15:0] rdata_ff;

   logic [1:0]  mk;   // neighbor during moves
   logic [1:0]  lk;   // neighbor during loads
   logic        have_l;
   logic [5:0]  nr, nc;
   logic [AW-1:0] self_addr, ld_addr;
   logic        req_inside;

   assign mk = idx_ff[1:0];
   assign lk = 2'(idx_ff - 3'd1);
   assign self_addr  = addr_of(r_ff, c_ff);
   assign req_inside = (32'(req_row) < GRID_ROWS) && (32'(req_column) < GRID_COLUMNS);

   always_comb begin
      nr = lk[0] ? r_ff + 6'd1 : r_ff - 6'd1;
      nc = lk[1] ? c_ff + 6'd1 : c_ff - 6'd1;
      have_l = (lk[1] ? (c_ff < lc_ff) : (c_ff != 6'd0)) &&
               (lk[0] ? (r_ff < lr_ff) : (r_ff != 6'd0));
      if (idx_ff == 3'd0 || !have_l) begin
         ld_addr = self_addr;
      end else begin
         ld_addr = addr_of(nr, nc);
      end
   end

   // arithmetic
   logic [16:0] diff;
   logic [15:0] mag;
   logic [47:0] cube_prod;
   logic [15:0] span;
   logic [31:0] scale_prod;
   logic [31:0] dividend;
   logic        div_done;
   logic [15:0] amount;
   logic [17:0] h_try, n_try;
   logic [15:0] h_sat, n_sat;
   logic [16:0] dd;
   logic        recv_l;

   assign diff       = {1'b0, max_height_ff} - {1'b0, h_ff};
   assign mag        = diff[16] ? 16'(-diff) : diff[15:0];
   assign cube_prod  = sq_ff * mag;
   assign span       = dtop_ff - talus_ff;
   assign scale_prod = cube_ff * span;
   assign dividend   = scaled_ff * drop_ff[mk];

   tegrid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (dsum_ff),
      .done     (div_done),
      .quotient (amount)
   );

   assign h_try = neg_ff ? {2'b00, h_ff} + {2'b00, amount} : {2'b00, h_ff} - {2'b00, amount};
   assign n_try = neg_ff ? {2'b00, nval_ff[mk]} - {2'b00, amount}
                         : {2'b00, nval_ff[mk]} + {2'b00, amount};
   assign h_sat = h_try[17] ? 16'd0 : (h_try[16] ? 16'hFFFF : h_try[15:0]);
   assign n_sat = n_try[17] ? 16'd0 : (n_try[16] ? 16'hFFFF : n_try[15:0]);

   assign dd     = {1'b0, h_ff} - {1'b0, rdata_ff};
   assign recv_l = have_l && !dd[16] && (dd[15:0] > talus_ff);

   // memory
   logic [15:0]   height_store_ff [DEPTH];
   logic          mem_we, mem_re;
   logic [AW-1:0] waddr, raddr;
   logic [15:0]   wdata;

   always_comb begin
      mem_we = 1'b0;
      waddr  = self_addr;
      wdata  = h_ff;
      if (cmd.accept && req_cmd == tegrid_pkg::CMD_WRITE && req_inside) begin
         mem_we = 1'b1;
         waddr  = addr_of(req_row, req_column);
         wdata  = req_height_in;
      end else if (cmd.mv_apply) begin
         mem_we = 1'b1;
         waddr  = naddr_ff[mk];
         wdata  = n_sat;
      end else if (cmd.wr_self) begin
         mem_we = 1'b1;
      end
      mem_re = cmd.ld_issue || (cmd.accept && req_cmd == tegrid_pkg::CMD_READ);
      raddr  = cmd.accept ? addr_of(req_row, req_column) : ld_addr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         height_store_ff[waddr] <= wdata;
      end
      if (mem_re) begin
         rdata_ff <= height_store_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff <= 1'b0;
      end else begin
         rd_ok_ff <= cmd.accept && req_cmd == tegrid_pkg::CMD_READ && req_inside;
      end
   end

   assign rsp_height_out = rd_ok_ff ? rdata_ff : 16'd0;

   always_ff @(posedge clock) begin
      if (cmd.run_init) begin
         r_ff    <= 6'd0;
         c_ff    <= 6'd0;
         pass_ff <= 8'd0;
         lr_ff   <= (32'(last_row_ff) > GRID_ROWS - 1) ? 6'(GRID_ROWS - 1) : last_row_ff;
         lc_ff   <= (32'(last_column_ff) > GRID_COLUMNS - 1) ?
                    6'(GRID_COLUMNS - 1) : last_column_ff;
      end else if (cmd.wr_self) begin
         if (c_ff == lc_ff) begin
            c_ff <= 6'd0;
            if (r_ff == lr_ff) begin
               r_ff    <= 6'd0;
               pass_ff <= pass_ff + 8'd1;
            end else begin
               r_ff <= r_ff + 6'd1;
            end
         end else begin
            c_ff <= c_ff + 6'd1;
         end
      end

      if (cmd.run_init || cmd.idx_clr) begin
         idx_ff <= 3'd0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 3'd1;
      end

      if (cmd.ld_capture) begin
         if (idx_ff == 3'd0) begin
            h_ff    <= rdata_ff;
            dsum_ff <= 18'd0;
            dtop_ff <= 16'd0;
         end else begin
            recv_ff[lk]  <= recv_l;
            drop_ff[lk]  <= dd[15:0];
            nval_ff[lk]  <= rdata_ff;
            naddr_ff[lk] <= ld_addr;
            if (recv_l) begin
               dsum_ff <= dsum_ff + {2'b00, dd[15:0]};
               if (dd[15:0] > dtop_ff) begin
                  dtop_ff <= dd[15:0];
               end
            end
         end
      end

      if (cmd.mv_sq) begin
         sq_ff  <= mag * mag;
         neg_ff <= diff[16];
      end
      if (cmd.mv_cube) begin
         cube_ff <= cube_prod[47:32];
      end
      if (cmd.mv_scale) begin
         scaled_ff <= scale_prod[31:16];
      end
      if (cmd.mv_apply) begin
         h_ff <= h_sat;
      end
   end

   assign stat.pass_zero = pass_count_ff == 8'd0;
   assign stat.last_slot = idx_ff == 3'd4;
   assign stat.recv_cur  = recv_ff[mk];
   assign stat.last_k    = idx_ff == 3'd3;
   assign stat.div_done  = div_done;
   assign stat.at_end    = (c_ff == lc_ff) && (r_ff == lr_ff) &&
                           (pass_ff == pass_count_ff - 8'd1);

endmodule

// ===== hw/rtl/tegrid_ctrl.sv =====
module tegrid_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_cmd,
   input  tegrid_pkg::dp_stat_type stat,
   output tegrid_pkg::ctl_cmd_type cmd,
   output logic                    busy,
   output logic                    rsp_strobe,
   output logic                    rsp_run_done
);

   typedef enum logic [3:0] {
      IDLE, RUN_INIT, LD_ADDR, LD_DATA, MV_CHECK, MV_SQ, MV_CUBE,
      MV_SCALE, MV_DIV, MV_WAIT, MV_APPLY, WR_SELF
   } state_type;

   state_type state_ff;
   logic      strobe_ff;
   logic      done_ff;

   assign busy = state_ff != IDLE;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         IDLE:     cmd.accept = start;
         RUN_INIT: cmd.run_init = 1'b1;
         LD_ADDR:  cmd.ld_issue = 1'b1;
         LD_DATA: begin
            cmd.ld_capture = 1'b1;
            cmd.idx_clr    = stat.last_slot;
            cmd.idx_inc    = !stat.last_slot;
         end
         MV_CHECK: begin
            cmd.idx_clr = !stat.recv_cur && stat.last_k;
            cmd.idx_inc = !stat.recv_cur && !stat.last_k;
         end
         MV_SQ:    cmd.mv_sq = 1'b1;
         MV_CUBE:  cmd.mv_cube = 1'b1;
         MV_SCALE: cmd.mv_scale = 1'b1;
         MV_DIV:   cmd.div_start = 1'b1;
         MV_WAIT:  ;
         MV_APPLY: begin
            cmd.mv_apply = 1'b1;
            cmd.idx_clr  = stat.last_k;
            cmd.idx_inc  = !stat.last_k;
         end
         WR_SELF:  cmd.wr_self = 1'b1;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         strobe_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         done_ff   <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  if (req_cmd == tegrid_pkg::CMD_RUN) begin
                     state_ff <= RUN_INIT;
                  end else begin
                     strobe_ff <= 1'b1;
                  end
               end
            end
            RUN_INIT: begin
               if (stat.pass_zero) begin
                  strobe_ff <= 1'b1;
                  done_ff   <= 1'b1;
                  state_ff  <= IDLE;
               end else begin
                  state_ff <= LD_ADDR;
               end
            end
            LD_ADDR: state_ff <= LD_DATA;
            LD_DATA: state_ff <= stat.last_slot ? MV_CHECK : LD_ADDR;
            MV_CHECK: begin
               if (stat.recv_cur) begin
                  state_ff <= MV_SQ;
               end else if (stat.last_k) begin
                  state_ff <= WR_SELF;
               end
            end
            MV_SQ:    state_ff <= MV_CUBE;
            MV_CUBE:  state_ff <= MV_SCALE;
            MV_SCALE: state_ff <= MV_DIV;
            MV_DIV:   state_ff <= MV_WAIT;
            MV_WAIT: begin
               if (stat.div_done) begin
                  state_ff <= MV_APPLY;
               end
            end
            MV_APPLY: state_ff <= stat.last_k ? WR_SELF : MV_CHECK;
            WR_SELF: begin
               if (stat.at_end) begin
                  strobe_ff <= 1'b1;
                  done_ff   <= 1'b1;
                  state_ff  <= IDLE;
               end else begin
                  state_ff <= LD_ADDR;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_run_done = done_ff;

endmodule
